>>> rtl/metropolis_lennard_jones_sweep_defines.svh
// Assertion macros for the Metropolis Lennard-Jones sweep block.
// Depends on nothing; included by the top level.
`ifndef METROPOLIS_LENNARD_JONES_SWEEP_DEFINES_SVH
`define METROPOLIS_LENNARD_JONES_SWEEP_DEFINES_SVH
`ifndef SYNTH
`define MLJ_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define MLJ_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MLJ_ASSERT_IMP(label, clk, rst_n, a, c)
`define MLJ_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/mlj_pkg.sv
// Shared types and constants for the Metropolis Lennard-Jones sweep block.
// Depends on nothing.
package mlj_pkg;
    localparam int NumParticles = 20;
    localparam int FracBits = 16;
    localparam int IdxW = 6;
    localparam int PosW = 20;
    localparam logic [29:0] PotCap = 30'h3FFF_FFFF;
    localparam logic [1:0] CFG_MAX_STEP = 2'd0;
    localparam logic [1:0] CFG_KT = 2'd1;
    localparam logic [1:0] CFG_BOX = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic start;      // latch request, form trial
        logic pair_ld;    // load operands for pair step
        logic pair_op;    // run one arithmetic step
        logic exp_op;     // ratio/accept phase step
        logic commit;     // write back, update accum
    } t_cmd;

    typedef struct packed {
        logic step_done;
    } t_sts;

    // reset lattice positions, modulo box 5.6 (367002)
    function automatic logic [PosW-1:0] lat_x(input int i);
        longint col;
        longint v;
        col = 2 * (i % 5) + i / 5;
        v = (367002 * col / 10) % 367002;
        return v[PosW-1:0];
    endfunction

    function automatic logic [PosW-1:0] lat_y(input int i);
        longint v;
        v = (367002 * 87 * (i / 5) / 500) % 367002;
        return v[PosW-1:0];
    endfunction
endpackage

>>> rtl/mlj_ctrl.sv
// Sequencer for one Metropolis move.
// Depends on mlj_pkg.
module mlj_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  mlj_pkg::t_sts i_sts,
    output mlj_pkg::t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_PAIR = 5'b00100,
        S_EXP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.pair_ld = 1'b1;
                n_state = S_PAIR;
            end
            S_PAIR: begin
                o_cmd.pair_op = 1'b1;
                if (i_sts.step_done) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.exp_op = 1'b1;
                if (i_sts.step_done) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

>>> rtl/mlj_dp.sv
// Datapath: trial step, pair energies with a serial divider, exp series, commit.
// Depends on mlj_pkg.
module mlj_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mlj_pkg::t_cmd i_cmd,
    output mlj_pkg::t_sts o_sts,
    input  logic [18:0]   i_max_step,
    input  logic [19:0]   i_kt,
    input  logic [19:0]   i_box,
    input  logic [15:0]   i_rand_step_x,
    input  logic [15:0]   i_rand_step_y,
    input  logic [15:0]   i_rand_accept,
    output logic [5:0]    o_particle_index,
    output logic          o_accepted,
    output logic [16:0]   o_accept_ratio,
    output logic [22:0]   o_sweep_ratio_sum,
    output logic          o_sweep_end
);
    localparam int N = mlj_pkg::NumParticles;
    localparam int W = mlj_pkg::PosW;
    localparam int IW = $clog2(N);

    // position stores with lattice reset
    logic [W-1:0] r_px [N];
    logic [W-1:0] r_py [N];
    logic [IW-1:0] r_idx, r_j;
    logic [22:0]  r_accum;
    logic [15:0]  r_ua;
    logic signed [22:0] r_tx, r_ty;
    logic [20:0]  r_len;
    logic [19:0]  r_kt;
    logic signed [47:0] r_de;

    // micro-step sequencing inside pair phase
    logic [4:0]   r_ph;
    logic         r_which;   // 0: trial, 1: old
    logic signed [22:0] r_ax, r_ay;
    logic [W-1:0] r_bx, r_by;
    logic signed [47:0] r_a;  // general work register
    logic signed [47:0] r_b;
    logic [47:0]  r_s, r_s2, r_s3;
    logic [47:0]  r_rem, r_quo, r_den;
    logic [6:0]   r_cnt;
    logic signed [30:0] r_pot_t;
    logic [3:0]   r_k;
    logic [47:0]  r_t;
    logic [47:0]  r_r30;
    logic [4:0]   r_n;
    logic [16:0]  r_ratio;
    logic         r_acc;

    logic signed [22:0] v_ax, v_bx;
    logic [47:0]  v_sub;
    logic [47:0]  v_remsh;
    logic signed [47:0] v_mod;

    // Horner product and divide by k through a reciprocal
    logic [63:0]  v_hprod;
    logic [63:0]  v_kprod;
    logic [33:0]  v_recip;
    logic [29:0]  v_kq;

    // trial step terms
    logic [19:0] v_len20;
    logic [20:0] v_len;
    logic [20:0] v_step;
    logic signed [17:0] v_ux, v_uy;
    logic signed [40:0] v_mx, v_my;

    assign v_len20 = (i_box < 20'd65536) ? 20'd65536 : i_box;
    assign v_len = {1'b0, v_len20};
    assign v_step = ({2'b0, i_max_step} > v_len) ? v_len : {2'b0, i_max_step};
    assign v_ux = 18'sd2 * $signed({2'b0, i_rand_step_x}) - 18'sd65536;
    assign v_uy = 18'sd2 * $signed({2'b0, i_rand_step_y}) - 18'sd65536;
    assign v_mx = v_ux * $signed({1'b0, v_step});
    assign v_my = v_uy * $signed({1'b0, v_step});

    // restoring divider step: r_rem/r_den, quotient into r_quo
    assign v_remsh = {r_rem[46:0], r_quo[47]};
    assign v_sub = v_remsh - r_den;

    // alias of r_a, used in the in-box check of the wrapped trial
    assign v_mod = r_a;

    // series term r*t in Q30 and its quotient by k (exact for x below 2^30)
    assign v_hprod = r_r30[31:0] * r_t[31:0];
    always_comb begin
        case (r_k)
            4'd2: v_recip = 34'd8589934592;
            4'd3: v_recip = 34'd5726623062;
            4'd4: v_recip = 34'd4294967296;
            4'd5: v_recip = 34'd3435973837;
            4'd6: v_recip = 34'd2863311531;
            4'd7: v_recip = 34'd2454267027;
            4'd8: v_recip = 34'd2147483648;
            4'd9: v_recip = 34'd1908874354;
            default: v_recip = '0;
        endcase
    end
    assign v_kprod = r_quo[29:0] * v_recip;
    assign v_kq = (r_k == 4'd1) ? r_quo[29:0] : 30'(v_kprod >> 34);

    logic v_done;
    assign o_sts.step_done = v_done;

    always_comb begin
        v_ax = r_ax;
        v_bx = $signed({3'b0, r_bx});
    end

    // main sequencer of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_px[i] <= mlj_pkg::lat_x(i);
                r_py[i] <= mlj_pkg::lat_y(i);
            end
            r_idx <= '0;
            r_accum <= '0;
            r_ph <= '0;
        end else begin
            if (i_cmd.start) begin
                r_ua <= i_rand_accept;
                r_len <= v_len;
                r_kt <= (i_kt == 20'd0) ? 20'd1 : i_kt;
                r_tx <= $signed({3'b0, r_px[r_idx]}) + 23'(v_mx >>> 16);
                r_ty <= $signed({3'b0, r_py[r_idx]}) + 23'(v_my >>> 16);
                r_de <= '0;
            end
            if (i_cmd.pair_ld) begin
                r_j <= '0;
                r_which <= 1'b0;
                r_ph <= '0;
            end
            if (i_cmd.pair_op) begin
                case (r_ph)
                    // pick partner or skip self
                    5'd0: begin
                        if (r_j == r_idx) begin
                            r_ph <= 5'd15;
                        end else begin
                            r_ax <= r_which ? $signed({3'b0, r_px[r_idx]}) : r_tx;
                            r_ay <= r_which ? $signed({3'b0, r_py[r_idx]}) : r_ty;
                            r_bx <= r_px[r_j];
                            r_by <= r_py[r_j];
                            r_ph <= 5'd1;
                        end
                    end
                    // dx and dy differences
                    5'd1: begin
                        r_a <= 48'(r_ax - v_bx);
                        r_b <= 48'(r_ay - $signed({3'b0, r_by}));
                        r_ph <= 5'd2;
                    end
                    // wrap dx,dy into [0,len) by repeated correction
                    5'd2: begin
                        if (r_a < 0) r_a <= r_a + 48'(r_len);
                        else if (r_a >= 48'(r_len)) r_a <= r_a - 48'(r_len);
                        else if (r_b < 0) r_b <= r_b + 48'(r_len);
                        else if (r_b >= 48'(r_len)) r_b <= r_b - 48'(r_len);
                        else r_ph <= 5'd3;
                    end
                    // minimum image
                    5'd3: begin
                        if ((r_a <<< 1) > 48'(r_len)) r_a <= r_a - 48'(r_len);
                        if ((r_b <<< 1) > 48'(r_len)) r_b <= r_b - 48'(r_len);
                        r_ph <= 5'd4;
                    end
                    // square the half-box differences, which fit 21 signed bits
                    5'd4: begin
                        r_s <= 48'($signed(r_a[20:0]) * $signed(r_a[20:0]));
                        r_ph <= 5'd5;
                    end
                    5'd5: begin
                        r_s2 <= 48'($signed(r_b[20:0]) * $signed(r_b[20:0]));
                        r_ph <= 5'd6;
                    end
                    // r2, and divider setup for 2^32 / r2
                    5'd6: begin
                        r_den <= (r_s + r_s2) >> 16;
                        r_quo <= 48'h1 << 32;
                        r_rem <= '0;
                        r_cnt <= 7'd48;
                        r_ph <= 5'd7;
                    end
                    5'd7: begin
                        if (r_den == '0) begin
                            r_pot_t <= mlj_pkg::PotCap;
                            r_ph <= 5'd14;
                        end else if (r_cnt == 7'd0) begin
                            r_s <= r_quo;
                            r_ph <= 5'd8;
                        end else begin
                            if (!v_sub[47]) begin
                                r_rem <= v_sub;
                                r_quo <= {r_quo[46:0], 1'b1};
                            end else begin
                                r_rem <= v_remsh;
                                r_quo <= {r_quo[46:0], 1'b0};
                            end
                            r_cnt <= r_cnt - 7'd1;
                        end
                    end
                    5'd8: begin
                        if (r_s >= (48'd4 << 16)) begin
                            r_pot_t <= mlj_pkg::PotCap;
                            r_ph <= 5'd14;
                        end else begin
                            r_s2 <= 48'((r_s[17:0] * r_s[17:0]) >> 16);
                            r_ph <= 5'd9;
                        end
                    end
                    5'd9: begin
                        r_s3 <= 48'((r_s2[19:0] * r_s[17:0]) >> 16);
                        r_ph <= 5'd10;
                    end
                    5'd10: begin
                        r_s2 <= 48'((r_s3[21:0] * r_s3[21:0]) >> 16);
                        r_ph <= 5'd11;
                    end
                    5'd11: begin
                        r_a <= $signed((r_s2 - r_s3) << 2);
                        r_ph <= 5'd12;
                    end
                    // cap the potential, keep its sign when attractive
                    5'd12: begin
                        r_pot_t <= (r_a > $signed(48'(mlj_pkg::PotCap))) ?
                            mlj_pkg::PotCap : r_a[30:0];
                        r_ph <= 5'd14;
                    end
                    // accumulate: trial adds, old subtracts
                    5'd14: begin
                        if (r_which) r_de <= r_de - 48'(r_pot_t);
                        else r_de <= r_de + 48'(r_pot_t);
                        if (r_which) r_ph <= 5'd15;
                        else begin
                            r_which <= 1'b1;
                            r_ph <= 5'd0;
                        end
                    end
                    // next partner
                    5'd15: begin
                        r_which <= 1'b0;
                        r_j <= r_j + 1'b1;
                        if (r_j == IW'(N - 1)) begin
                            r_ph <= 5'd16;
                        end else begin
                            r_ph <= 5'd0;
                        end
                    end
                    5'd16: r_ph <= 5'd0;
                    default: r_ph <= 5'd0;
                endcase
            end
            if (i_cmd.exp_op) begin
                case (r_ph)
                    // classify dE, set up y = dE*65536/kT division
                    5'd0: begin
                        if (r_de <= 0) begin
                            r_ratio <= 17'd65536;
                            r_ph <= 5'd6;
                        end else if (r_de >= 48'(r_kt) * 48'sd12) begin
                            r_ratio <= 17'd0;
                            r_ph <= 5'd6;
                        end else begin
                            r_quo <= 48'(r_de) << 16;
                            r_rem <= '0;
                            r_den <= 48'(r_kt);
                            r_cnt <= 7'd48;
                            r_ph <= 5'd1;
                        end
                    end
                    5'd1: begin
                        if (r_cnt == 7'd0) begin
                            r_n <= '0;
                            r_s <= r_quo;
                            r_ph <= 5'd2;
                        end else begin
                            if (!v_sub[47]) begin
                                r_rem <= v_sub;
                                r_quo <= {r_quo[46:0], 1'b1};
                            end else begin
                                r_rem <= v_remsh;
                                r_quo <= {r_quo[46:0], 1'b0};
                            end
                            r_cnt <= r_cnt - 7'd1;
                        end
                    end
                    // y / ln2 by repeated subtraction (y < 12*65536)
                    5'd2: begin
                        if (r_s >= 48'd45426) begin
                            r_s <= r_s - 48'd45426;
                            r_n <= r_n + 5'd1;
                        end else begin
                            r_r30 <= r_s << 14;
                            r_t <= 48'h1 << 30;
                            r_k <= 4'd9;
                            r_ph <= 5'd3;
                        end
                    end
                    // Horner product
                    5'd3: begin
                        r_quo <= 48'(v_hprod >> 30);
                        r_ph <= 5'd4;
                    end
                    // divide by k, then t = 1 - q
                    5'd4: begin
                        r_t <= (48'h1 << 30) - 48'(v_kq);
                        if (r_k == 4'd1) r_ph <= 5'd5;
                        else begin
                            r_k <= r_k - 4'd1;
                            r_ph <= 5'd3;
                        end
                    end
                    5'd5: begin
                        r_ratio <= 17'(r_t >> (6'd14 + 6'(r_n)));
                        r_ph <= 5'd6;
                    end
                    5'd6: begin
                        r_acc <= ({1'b0, r_ua} < r_ratio);
                        r_ph <= 5'd7;
                    end
                    // hold while the trial wraps into the box
                    5'd7: ;
                    default: r_ph <= 5'd0;
                endcase
            end
            // write back and advance particle
            if (i_cmd.commit) begin
                if (r_acc) begin
                    r_px[r_idx] <= W'(r_a[W-1:0]);
                    r_py[r_idx] <= W'(r_b[W-1:0]);
                end
                o_particle_index <= 6'(r_idx);
                o_accepted <= r_acc;
                o_accept_ratio <= r_ratio;
                o_sweep_ratio_sum <= r_accum + 23'(r_ratio);
                o_sweep_end <= (r_idx == IW'(N - 1));
                if (r_idx == IW'(N - 1)) begin
                    r_accum <= '0;
                    r_idx <= '0;
                end else begin
                    r_accum <= r_accum + 23'(r_ratio);
                    r_idx <= r_idx + 1'b1;
                end
            end
            // wrap trial into box during the accept phase
            if (i_cmd.exp_op && r_ph == 5'd6) begin
                r_a <= 48'(r_tx);
                r_b <= 48'(r_ty);
            end
            if (i_cmd.exp_op && r_ph == 5'd7) begin
                if (r_a < 0) r_a <= r_a + 48'(r_len);
                else if (r_a >= 48'(r_len)) r_a <= r_a - 48'(r_len);
                else if (r_b < 0) r_b <= r_b + 48'(r_len);
                else if (r_b >= 48'(r_len)) r_b <= r_b - 48'(r_len);
                else r_ph <= 5'd8;
            end
        end
    end

    logic v_pair_done, v_exp_done, v_wr_ok;
    assign v_wr_ok = !(v_mod < 0) && (v_mod < 48'(r_len)) &&
        !(r_b < 0) && (r_b < 48'(r_len));
    assign v_pair_done = i_cmd.pair_op && (r_ph == 5'd16);
    assign v_exp_done = i_cmd.exp_op && (r_ph == 5'd7) && v_wr_ok;
    assign v_done = v_pair_done || v_exp_done;
    logic unused;
    assign unused = ^{v_ax, r_s2[47], r_den[0]};
endmodule

>>> rtl/metropolis_lennard_jones_sweep.sv
// Metropolis Lennard-Jones sweep, one move per request.
// Each move computes, for each of 19 partners, two potentials, each set by the
// serial 48-step divide for 1/r2, then dE/kT and the exp series.
// Throughput: one request at a time; stall stays high until the result leaves.
// Reset (synchronous, active low) loads the hexagonal lattice and defaults.
`include "metropolis_lennard_jones_sweep_defines.svh"
module metropolis_lennard_jones_sweep (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_rand_step_x,
    input  logic [15:0] i_rand_step_y,
    input  logic [15:0] i_rand_accept,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_particle_index,
    output logic        o_accepted,
    output logic [16:0] o_accept_ratio,
    output logic [22:0] o_sweep_ratio_sum,
    output logic        o_sweep_end
);
    logic [18:0] r_max_step;
    logic [19:0] r_kt, r_box;
    mlj_pkg::t_cmd v_cmd;
    mlj_pkg::t_sts v_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= 19'd6554;
            r_kt <= 20'd39322;
            r_box <= 20'd367002;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlj_pkg::CFG_MAX_STEP: r_max_step <= i_cfg_data[18:0];
                mlj_pkg::CFG_KT: r_kt <= i_cfg_data;
                mlj_pkg::CFG_BOX: r_box <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlj_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(v_sts), .o_cmd(v_cmd)
    );

    mlj_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(v_cmd), .o_sts(v_sts),
        .i_max_step(r_max_step), .i_kt(r_kt), .i_box(r_box),
        .i_rand_step_x(i_rand_step_x), .i_rand_step_y(i_rand_step_y),
        .i_rand_accept(i_rand_accept), .o_particle_index(o_particle_index),
        .o_accepted(o_accepted), .o_accept_ratio(o_accept_ratio),
        .o_sweep_ratio_sum(o_sweep_ratio_sum), .o_sweep_end(o_sweep_end)
    );

    // a result never exceeds one in Q.16
    `MLJ_ASSERT_IMP(a_ratio_max, i_clk, i_rst_n, o_valid, o_accept_ratio <= 17'd65536)
    // accepting needs a non-zero ratio
    `MLJ_ASSERT_IMP(a_acc_ratio, i_clk, i_rst_n, o_valid && o_accepted, o_accept_ratio != 17'd0)
    // no request taken while a result waits
    `MLJ_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, o_stall)
endmodule

>>> dv/metropolis_lennard_jones_sweep_tb.sv
// Testbench for metropolis_lennard_jones_sweep: drives Monte Carlo move requests
// and register writes, predicts each move result and checks all its fields.
// Depends on mlj_pkg and the metropolis_lennard_jones_sweep RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [5:0]  idx;
    logic        acc;
    logic [16:0] ratio;
    logic [22:0] sum;
    logic        last;
} t_move_result;

class move_scoreboard;
    logic [19:0]  px [mlj_pkg::NumParticles];
    logic [19:0]  py [mlj_pkg::NumParticles];
    int unsigned  cur_particle;
    logic [22:0]  ratio_sum;
    logic [18:0]  step_reg;
    logic [19:0]  kt_reg;
    logic [19:0]  box_reg;
    t_move_result pending_moves [$];
    int unsigned  fail_count;

    function new();
        longint box0;
        box0 = 367002;
        for (int i = 0; i < mlj_pkg::NumParticles; i++) begin
            px[i] = 20'((box0 * (2 * (i % 5) + i / 5) / 10) % box0);
            py[i] = 20'((box0 * 87 * (i / 5) / 500) % box0);
        end
        cur_particle = 0;
        ratio_sum = '0;
        step_reg = 19'd6554;
        kt_reg = 20'd39322;
        box_reg = 20'd367002;
        fail_count = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [19:0] data);
        case (index)
            mlj_pkg::CFG_MAX_STEP: step_reg = data[18:0];
            mlj_pkg::CFG_KT:       kt_reg = data;
            mlj_pkg::CFG_BOX:      box_reg = data;
            default: ;
        endcase
    endfunction

    function longint wrap(longint v, longint len);
        longint m;
        m = v % len;
        if (m < 0) m += len;
        return m;
    endfunction

    function longint min_img(longint d, longint len);
        longint m;
        m = wrap(d, len);
        if (2 * m > len) m -= len;
        return m;
    endfunction

    // truncated Lennard-Jones pair potential, saturated at the cap
    function longint pair_pot(longint ax, longint ay, longint bx, longint by, longint len);
        longint dx, dy, r2, s, s2, s3, s6, p, cap;
        cap = (longint'(1) << 30) - 1;
        dx = min_img(ax - bx, len);
        dy = min_img(ay - by, len);
        r2 = (dx * dx + dy * dy) >>> 16;
        if (r2 <= 0) return cap;
        s = (longint'(1) << 32) / r2;
        if (s >= (longint'(4) << 16)) return cap;
        s2 = (s * s) >>> 16;
        s3 = (s2 * s) >>> 16;
        s6 = (s3 * s3) >>> 16;
        p = 4 * (s6 - s3);
        if (p > cap) p = cap;
        return p;
    endfunction

    // exp(-y/65536) in Q16 through a Horner series in Q30
    function longint exp_neg(longint y);
        longint n, r30, t, one30;
        one30 = longint'(1) << 30;
        n = y / 45426;
        r30 = (y - n * 45426) << 14;
        t = one30;
        for (int k = 9; k >= 1; k--)
            t = one30 - ((r30 * t) >>> 30) / k;
        return t >>> (14 + n);
    endfunction

    // predict the move for one accepted request and advance the sweep
    function void note_request(logic [15:0] ux, logic [15:0] uy, logic [15:0] ua);
        longint len, stp, kt, tx, ty, de, ratio;
        int unsigned i;
        t_move_result r;
        len = (box_reg < 20'd65536) ? 65536 : longint'(box_reg);
        stp = (longint'(step_reg) > len) ? len : longint'(step_reg);
        kt = (kt_reg == 0) ? 1 : longint'(kt_reg);
        i = cur_particle;
        tx = longint'(px[i]) + (((2 * longint'(ux) - 65536) * stp) >>> 16);
        ty = longint'(py[i]) + (((2 * longint'(uy) - 65536) * stp) >>> 16);
        de = 0;
        for (int j = 0; j < mlj_pkg::NumParticles; j++) begin
            if (j == i) continue;
            de += pair_pot(tx, ty, px[j], py[j], len)
                - pair_pot(px[i], py[i], px[j], py[j], len);
        end
        if (de <= 0) ratio = 65536;
        else if (de >= 12 * kt) ratio = 0;
        else ratio = exp_neg((de << 16) / kt);
        if (ratio > 65536) ratio = 65536;
        r.acc = ratio > longint'(ua);
        if (r.acc) begin
            px[i] = 20'(wrap(tx, len));
            py[i] = 20'(wrap(ty, len));
        end
        ratio_sum = ratio_sum + 23'(ratio);
        r.idx = 6'(i);
        r.ratio = 17'(ratio);
        r.sum = ratio_sum;
        r.last = (i == mlj_pkg::NumParticles - 1);
        pending_moves.push_back(r);
        if (r.last) begin
            ratio_sum = '0;
            cur_particle = 0;
        end else begin
            cur_particle = i + 1;
        end
    endfunction

    function void check_result(t_move_result got);
        t_move_result want;
        if (pending_moves.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result: %p", got);
            return;
        end
        want = pending_moves.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: expected %p got %p", want, got);
        end
    endfunction

    function int outstanding();
        return pending_moves.size();
    endfunction
endclass

module metropolis_lennard_jones_sweep_tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [19:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_rand_step_x;
    logic [15:0] i_rand_step_y;
    logic [15:0] i_rand_accept;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_particle_index;
    logic        o_accepted;
    logic [16:0] o_accept_ratio;
    logic [22:0] o_sweep_ratio_sum;
    logic        o_sweep_end;

    move_scoreboard sb;
    int          burst_left;
    int          stall_mode;
    int          stall_run;

    metropolis_lennard_jones_sweep uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // hold the receiver stall in stretches of random mode
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run = $urandom_range(5, 80);
        end
        stall_run--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= $urandom_range(0, 1);
        endcase
    end

    // check every result that leaves the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_particle_index, o_accepted, o_accept_ratio,
                             o_sweep_ratio_sum, o_sweep_end});
    end

    // offer one request after a possible gap, hold it until accepted
    task automatic send_request(input logic [15:0] ux, input logic [15:0] uy,
                                input logic [15:0] ua);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            burst_left = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_rand_step_x = ux;
        i_rand_step_y = uy;
        i_rand_accept = ua;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(ux, uy, ua);
        burst_left--;
    endtask

    // drop valid and wait for every expected result plus settling time
    task automatic drain(input int settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] index, input logic [19:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_phase(input logic [19:0] stp, input logic [19:0] kt,
                             input logic [19:0] box);
        set_register(mlj_pkg::CFG_MAX_STEP, stp);
        set_register(mlj_pkg::CFG_KT, kt);
        set_register(mlj_pkg::CFG_BOX, box);
    endtask

    task automatic random_moves(input int count);
        for (int n = 0; n < count; n++) begin
            // pause once mid-run until every result is back
            if (n == count / 2 && count > 50) drain(0);
            send_request($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
        end
    endtask

    initial begin
        #500_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new();
        burst_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = mlj_pkg::CFG_MAX_STEP;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_rand_step_x = '0;
        i_rand_step_y = '0;
        i_rand_accept = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes and the midpoint step at reset settings
        send_request(16'h0000, 16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'h8000, 16'h8000, 16'h0000);
        send_request(16'h8000, 16'h8000, 16'hFFFF);
        send_request(16'h0000, 16'hFFFF, 16'h8000);
        send_request(16'hFFFF, 16'h0000, 16'h0001);
        send_request(16'h5555, 16'hAAAA, 16'h7FFF);
        send_request(16'hAAAA, 16'h5555, 16'hFFFE);
        drain(30);
        // large step, hottest kT, largest box
        set_phase(20'd367001, 20'd1048575, 20'd1048575);
        send_request(16'h0000, 16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'hFFFF, 16'h0000);
        drain(30);
        // zero step, zero kT (acts as one), smallest legal box
        set_phase(20'd0, 20'd0, 20'd65536);
        send_request(16'h1234, 16'hFEDC, 16'h0000);
        send_request(16'hFFFF, 16'h0000, 16'hFFFF);
        drain(30);
        // oversized step, kT of one, box under one length
        set_phase(20'h7FFFF, 20'd1, 20'd1000);
        send_request(16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'h0000, 16'h0000);
        random_moves(60);
        drain(30);
        set_phase(20'd367001, 20'd1048575, 20'd1048575);
        random_moves(130);
        drain(30);
        set_phase(20'd20000, 20'd65536, 20'd367002);
        random_moves(140);
        drain(30);
        set_phase(20'd0, 20'd0, 20'd65536);
        random_moves(60);
        drain(30);
        set_phase(20'd6554, 20'd39322, 20'd367002);
        random_moves(230);

        drain(300);
        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
